// ===== rtl/pc_pkg.sv =====
`default_nettype none
package pc_pkg;

  localparam int BUF_LEN_DEFAULT = 128;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  localparam logic [1:0] KIND_WORK = 2'd0;
  localparam logic [1:0] KIND_REL  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef enum logic [2:0] {
    ST_OK,
    ST_PARENT,
    ST_COPY,
    ST_SEP,
    ST_MANY,
    ST_UNTERM,
    ST_FULL
  } pc_status_t;

  typedef enum logic {
    PC_IDLE,
    PC_EXEC
  } pc_state_t;

  typedef struct packed {
    logic res_we;
    logic stk_we;
  } pc_wen_t;

endpackage
`default_nettype wire

// ===== rtl/pc_mem.sv =====
`default_nettype none
module pc_mem #(
  parameter int BUF_LEN = pc_pkg::BUF_LEN_DEFAULT
) (
  input  wire logic                             clk,
  input  wire pc_pkg::pc_wen_t                  wen,
  input  wire logic [$clog2(BUF_LEN)-1:0]       res_waddr,
  input  wire logic [7:0]                       res_wdata,
  input  wire logic [$clog2(BUF_LEN)-1:0]       res_raddr,
  output logic      [7:0]                       res_rdata,
  input  wire logic [$clog2(BUF_LEN)-1:0]       stk_waddr,
  input  wire logic [$clog2(BUF_LEN+2)-1:0]     stk_wdata,
  input  wire logic [$clog2(BUF_LEN)-1:0]       stk_raddr,
  output logic      [$clog2(BUF_LEN+2)-1:0]     stk_rdata
);

  localparam int CW = $clog2(BUF_LEN + 2);

  logic [7:0]    result_store      [BUF_LEN];
  logic [CW-1:0] name_length_stack [BUF_LEN];

  always_ff @(posedge clk) begin
    if (wen.res_we) begin
      result_store[res_waddr] <= res_wdata;
    end
    res_rdata <= result_store[res_raddr];
  end

  always_ff @(posedge clk) begin
    if (wen.stk_we) begin
      name_length_stack[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= name_length_stack[stk_raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/pc_ctrl.sv =====
`default_nettype none
module pc_ctrl #(
  parameter int BUF_LEN = pc_pkg::BUF_LEN_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_fire,
  input  wire logic [1:0]                       in_kind,
  input  wire logic [7:0]                       in_ch,
  input  wire logic [6:0]                       in_idx,
  output logic                                  ready,
  input  wire logic                             out_busy,
  output logic                                  res_fire,
  output logic                                  res_is_report,
  output logic      [2:0]                       res_status,
  output logic      [6:0]                       res_length,
  output logic      [7:0]                       res_out_ch,
  output pc_pkg::pc_wen_t                       wen,
  output logic      [$clog2(BUF_LEN)-1:0]       res_waddr,
  output logic      [7:0]                       res_wdata,
  output logic      [$clog2(BUF_LEN)-1:0]       res_raddr,
  input  wire logic [7:0]                       res_rdata,
  output logic      [$clog2(BUF_LEN)-1:0]       stk_waddr,
  output logic      [$clog2(BUF_LEN+2)-1:0]     stk_wdata,
  output logic      [$clog2(BUF_LEN)-1:0]       stk_raddr,
  input  wire logic [$clog2(BUF_LEN+2)-1:0]     stk_rdata
);

  localparam int AW = $clog2(BUF_LEN);
  localparam int CW = $clog2(BUF_LEN + 2);
  localparam int SW = CW + 1;
  localparam int LW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] BL  = CW'(BUF_LEN);
  localparam logic [CW-1:0] SAT = CW'(BUF_LEN + 1);
  localparam logic [SW-1:0] BLS = SW'(BUF_LEN);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v < SAT) ? v + CW'(1) : SAT;
  endfunction

  pc_pkg::pc_state_t  state, state_next;
  logic [1:0]         kind_q;
  logic [7:0]         ch_q;
  logic [6:0]         idx_q;

  logic [CW-1:0]      stack_top, stack_top_next;
  logic [CW-1:0]      result_fill, result_fill_next;
  logic [CW-1:0]      source_position, source_position_next;
  logic [CW-1:0]      name_length, name_length_next;
  logic [1:0]         dot_pattern, dot_pattern_next;
  pc_pkg::pc_status_t error_latch, error_latch_next;
  logic               job_done, job_done_next;

  logic               is_path, clr, has_res, commit;
  logic [CW-1:0]      e_top, e_fill, e_sp, e_nl;
  logic [1:0]         e_dot;
  pc_pkg::pc_status_t e_err, st;
  logic [SW-1:0]      sum;
  logic [CW-1:0]      top_m1, len_v;
  logic [LW-1:0]      len_w, idx_w, idx_in_w;
  pc_pkg::pc_wen_t    wen_raw;

  assign top_m1    = stack_top - CW'(1);
  assign stk_raddr = top_m1[AW-1:0];
  assign idx_in_w  = LW'(in_idx);
  assign idx_w     = LW'(idx_q);
  assign res_raddr = (state == pc_pkg::PC_IDLE) ? idx_in_w[AW-1:0] : idx_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q <= in_kind;
      ch_q   <= in_ch;
      idx_q  <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pc_pkg::PC_IDLE;
      stack_top       <= '0;
      result_fill     <= '0;
      source_position <= '0;
      name_length     <= '0;
      dot_pattern     <= '0;
      error_latch     <= pc_pkg::ST_OK;
      job_done        <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        stack_top       <= stack_top_next;
        result_fill     <= result_fill_next;
        source_position <= source_position_next;
        name_length     <= name_length_next;
        dot_pattern     <= dot_pattern_next;
        error_latch     <= error_latch_next;
        job_done        <= job_done_next;
      end
    end
  end

  always_comb begin
    is_path = (kind_q == pc_pkg::KIND_WORK) || (kind_q == pc_pkg::KIND_REL);
    clr     = is_path && job_done;
    e_top   = clr ? '0 : stack_top;
    e_fill  = clr ? '0 : result_fill;
    e_sp    = clr ? '0 : source_position;
    e_nl    = clr ? '0 : name_length;
    e_dot   = clr ? '0 : dot_pattern;
    e_err   = clr ? pc_pkg::ST_OK : error_latch;
    sum     = {1'b0, e_fill} + {1'b0, e_nl};

    stack_top_next       = e_top;
    result_fill_next     = e_fill;
    source_position_next = e_sp;
    name_length_next     = e_nl;
    dot_pattern_next     = e_dot;
    error_latch_next     = e_err;
    job_done_next        = clr ? 1'b0 : job_done;
    wen_raw              = '0;
    res_waddr            = sum[AW-1:0];
    res_wdata            = ch_q;
    stk_waddr            = e_top[AW-1:0];
    stk_wdata            = e_nl + CW'(1);
    st                   = pc_pkg::ST_OK;

    if (is_path && e_err == pc_pkg::ST_OK) begin
      if (ch_q == pc_pkg::CH_SLASH || ch_q == pc_pkg::CH_NUL) begin
        if (e_nl != '0) begin
          if (e_nl == CW'(1) && e_dot[0]) begin
            st = pc_pkg::ST_OK;
          end else if (e_nl == CW'(2) && e_dot == 2'b11) begin
            if (e_top == '0 || e_top > BL) begin
              st = pc_pkg::ST_PARENT;
            end else begin
              result_fill_next = (stk_rdata > e_fill) ? '0 : e_fill - stk_rdata;
              stack_top_next   = e_top - CW'(1);
            end
          end else begin
            if (e_sp > BL || sum > BLS) begin
              st = pc_pkg::ST_COPY;
            end else if (sum >= BLS) begin
              st = pc_pkg::ST_SEP;
            end else begin
              wen_raw.res_we   = 1'b1;
              res_wdata        = pc_pkg::CH_SLASH;
              result_fill_next = sum[CW-1:0] + CW'(1);
              if ({1'b0, e_top} + SW'(1) > BLS) begin
                st = pc_pkg::ST_MANY;
              end else begin
                wen_raw.stk_we = 1'b1;
                stack_top_next = e_top + CW'(1);
              end
            end
          end
        end
        if (st == pc_pkg::ST_OK && e_sp >= BL) begin
          st = pc_pkg::ST_UNTERM;
        end
        if (st == pc_pkg::ST_OK && ch_q == pc_pkg::CH_NUL && result_fill_next >= BL) begin
          st = pc_pkg::ST_FULL;
        end
        error_latch_next     = st;
        source_position_next = (ch_q == pc_pkg::CH_NUL) ? '0 : sat_inc(e_sp);
        name_length_next     = '0;
        dot_pattern_next     = '0;
      end else begin
        wen_raw.res_we = (sum < BLS);
        if (ch_q == pc_pkg::CH_DOT) begin
          if (e_nl == '0) begin
            dot_pattern_next[0] = 1'b1;
          end else if (e_nl == CW'(1)) begin
            dot_pattern_next[1] = 1'b1;
          end
        end
        name_length_next     = sat_inc(e_nl);
        source_position_next = sat_inc(e_sp);
      end
    end

    if (kind_q == pc_pkg::KIND_REL && ch_q == pc_pkg::CH_NUL) begin
      job_done_next = 1'b1;
    end

    len_v = (!job_done_next || error_latch_next != pc_pkg::ST_OK || result_fill_next == '0)
            ? '0 : result_fill_next - CW'(1);
    len_w = LW'(len_v);
  end

  always_comb begin
    unique case (state)
      pc_pkg::PC_IDLE: state_next = in_fire ? pc_pkg::PC_EXEC : pc_pkg::PC_IDLE;
      pc_pkg::PC_EXEC: state_next = commit ? pc_pkg::PC_IDLE : pc_pkg::PC_EXEC;
      default:         state_next = pc_pkg::PC_IDLE;
    endcase
  end

  always_comb begin
    ready   = (state == pc_pkg::PC_IDLE);
    has_res = (kind_q == pc_pkg::KIND_READ) ||
              (kind_q == pc_pkg::KIND_REL && ch_q == pc_pkg::CH_NUL);
    commit  = (state == pc_pkg::PC_EXEC) && !(has_res && out_busy);
    res_fire       = commit && has_res;
    wen.res_we     = commit && wen_raw.res_we;
    wen.stk_we     = commit && wen_raw.stk_we;
    res_is_report  = (kind_q != pc_pkg::KIND_READ);
    res_status     = error_latch_next;
    res_length     = len_w[6:0];
    res_out_ch     = (!res_is_report && idx_w < len_w && idx_w < LW'(BUF_LEN)) ? res_rdata : 8'h00;
  end

endmodule
`default_nettype wire

// ===== rtl/path_canonicalizer.sv =====
// A request's registered memory read of the result store and name stack runs as
// it is accepted; the update then registers its result into the output register.
// No new request is accepted until that update commits. A stalled output holds
// the update cycle until the result register frees.
// Reset is synchronous and clears the job state at once; the memories are not
// cleared and need no clearing pass.
`default_nettype none
module path_canonicalizer #(
  parameter int BUF_LEN = pc_pkg::BUF_LEN_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // ch[7:0], read_index[14:8]
  input  wire logic [1:0]  s_tuser,  // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,  // status[2:0], length[9:3], out_ch[17:10]
  output logic      [0:0]  m_tuser   // is_report[0]
);

  localparam int AW = $clog2(BUF_LEN);
  localparam int CW = $clog2(BUF_LEN + 2);

  pc_pkg::pc_wen_t wen;
  logic [AW-1:0]   res_waddr, res_raddr, stk_waddr, stk_raddr;
  logic [7:0]      res_wdata, res_rdata;
  logic [CW-1:0]   stk_wdata, stk_rdata;
  logic            in_fire, out_busy, res_fire, res_is_report;
  logic [2:0]      res_status;
  logic [6:0]      res_length;
  logic [7:0]      res_out_ch;

  assign in_fire  = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;

  pc_ctrl #(.BUF_LEN(BUF_LEN)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .in_kind       (s_tuser),
    .in_ch         (s_tdata[7:0]),
    .in_idx        (s_tdata[14:8]),
    .ready         (s_tready),
    .out_busy      (out_busy),
    .res_fire      (res_fire),
    .res_is_report (res_is_report),
    .res_status    (res_status),
    .res_length    (res_length),
    .res_out_ch    (res_out_ch),
    .wen           (wen),
    .res_waddr     (res_waddr),
    .res_wdata     (res_wdata),
    .res_raddr     (res_raddr),
    .res_rdata     (res_rdata),
    .stk_waddr     (stk_waddr),
    .stk_wdata     (stk_wdata),
    .stk_raddr     (stk_raddr),
    .stk_rdata     (stk_rdata)
  );

  pc_mem #(.BUF_LEN(BUF_LEN)) u_mem (
    .clk       (clk),
    .wen       (wen),
    .res_waddr (res_waddr),
    .res_wdata (res_wdata),
    .res_raddr (res_raddr),
    .res_rdata (res_rdata),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      m_tdata <= {6'b0, res_out_ch, res_length, res_status};
      m_tuser <= res_is_report;
    end
  end

  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("request accepted in back-to-back cycles");

  a_report_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[17:10] == 8'h00))
    else $error("report carries result data");

  a_error_no_length: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != 3'd0) |-> (m_tdata[9:3] == 7'd0))
    else $error("nonzero length with error status");

endmodule
`default_nettype wire
